### design/enbid_pkg.sv
// Package for the ELF note build-id scanner.
// Holds the channel payload types, the parser phase codes, note constants and helpers.
// No dependencies; every other design file uses it by scoped names.
`default_nettype none

package enbid_pkg;

    // Note header layout and build-id identification.
    localparam int unsigned HEADER_BYTES       = 12;
    localparam logic [3:0]  HDR_LAST_IDX       = 4'(HEADER_BYTES - 1);
    localparam logic [3:0]  HDR_SUM_IDX        = 4'd8;
    localparam logic [31:0] BUILD_ID_TYPE      = 32'd3;
    localparam logic [31:0] BUILD_ID_NAME_SIZE = 32'd4;

    // Input item: one byte of the note segment.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        segment_start;
        logic [31:0] segment_length;
    } in_t;

    // Result item: one hex character or a not-found marker.
    typedef struct packed {
        logic [7:0]  hex_char;
        logic        status;
        logic        is_last;
        logic [31:0] id_length;
    } out_t;

    // Record passed from the parser to the emitter through the queue.
    typedef struct packed {
        logic        not_found;
        logic [7:0]  data;
        logic        last;
        logic [31:0] id_length;
    } rec_t;

    // Write side of the queue.
    typedef struct packed {
        logic push;
        rec_t rec;
    } q_in_t;

    // Read side and status of the queue.
    typedef struct packed {
        logic valid;
        logic full;
        rec_t rec;
    } q_out_t;

    // Parser phases, one-hot.
    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_HEADER = 6'b000010,
        PH_NAME   = 6'b000100,
        PH_DESC   = 6'b001000,
        PH_EMIT   = 6'b010000,
        PH_DONE   = 6'b100000
    } phase_t;

    // Size rounded up to a multiple of four bytes.
    function automatic logic [32:0] pad4(input logic [31:0] n);
        logic [32:0] s;
        begin
            s = {1'b0, n} + 33'd3;
            return {s[32:2], 2'b00};
        end
    endfunction

    // Expected byte of the note name "GNU" plus terminator.
    function automatic logic [7:0] gnu_tag(input logic [1:0] idx);
        logic [7:0] c;
        begin
            case (idx)
                2'd0:    c = 8'h47;
                2'd1:    c = 8'h4E;
                2'd2:    c = 8'h55;
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

    // Lower-case ASCII hex digit of a nibble.
    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] c;
        begin
            if (nib < 4'd10) begin
                c = 8'h30 + {4'd0, nib};
            end else begin
                c = 8'h57 + {4'd0, nib};
            end
            return c;
        end
    endfunction

endpackage

`default_nettype wire

### design/enbid_front.sv
// Front part of the build-id scanner: accepts segment bytes and walks the note headers.
// Pushes one record per build-id byte, or one not-found record, into the queue.
// Depends on enbid_pkg.
`default_nettype none

module enbid_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire enbid_pkg::in_t  s_data,
    input  wire enbid_pkg::q_out_t q_rd,
    output enbid_pkg::q_in_t     q_wr
);

    enbid_pkg::phase_t phase_reg, phase_next;
    logic [31:0] bytes_left_reg, bytes_left_next;
    logic [3:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [32:0] part_left_reg, part_left_next;
    logic [31:0] name_len_reg, name_len_next;
    logic [31:0] desc_len_reg, desc_len_next;
    logic [31:0] kind_reg, kind_next;
    logic        match_reg, match_next;
    logic [33:0] bound_sum_reg, bound_sum_next;

    // Working copies after a possible segment restart.
    enbid_pkg::phase_t cur_phase;
    logic [31:0] cur_bl;
    logic [3:0]  cur_cnt;
    logic [31:0] cur_name, cur_desc, cur_kind;
    logic        cur_match;
    logic [31:0] bl_dec;
    logic [31:0] hdr_val;
    logic [31:0] ed_kind;
    logic        ed_match;
    logic        go_desc, go_end;
    logic        accept;

    // A new item is taken whenever the queue has room.
    assign s_ready = !q_rd.full;
    assign accept  = s_valid && s_ready;

    // Parse step for one accepted byte.
    always_comb begin
        phase_next     = phase_reg;
        bytes_left_next = bytes_left_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        part_left_next = part_left_reg;
        name_len_next  = name_len_reg;
        desc_len_next  = desc_len_reg;
        kind_next      = kind_reg;
        match_next     = match_reg;
        bound_sum_next = bound_sum_reg;
        q_wr           = '0;
        cur_phase      = phase_reg;
        cur_bl         = bytes_left_reg;
        cur_cnt        = hdr_cnt_reg;
        cur_name       = name_len_reg;
        cur_desc       = desc_len_reg;
        cur_kind       = kind_reg;
        cur_match      = match_reg;
        hdr_val        = '0;
        ed_kind        = kind_reg;
        ed_match       = match_reg;
        go_desc        = 1'b0;
        go_end         = 1'b0;

        if (accept && s_data.segment_start) begin
            cur_bl = s_data.segment_length;
            bytes_left_next = s_data.segment_length;
            if (s_data.segment_length < 32'(enbid_pkg::HEADER_BYTES)) begin
                cur_phase = enbid_pkg::PH_DONE;
                phase_next = enbid_pkg::PH_DONE;
                q_wr.push = 1'b1;
                q_wr.rec.not_found = 1'b1;
            end else begin
                cur_phase = enbid_pkg::PH_HEADER;
                cur_cnt   = '0;
                cur_name  = '0;
                cur_desc  = '0;
                cur_kind  = '0;
                cur_match = 1'b0;
                phase_next    = enbid_pkg::PH_HEADER;
                hdr_cnt_next  = '0;
                name_len_next = '0;
                desc_len_next = '0;
                kind_next     = '0;
                match_next    = 1'b0;
            end
        end

        bl_dec = cur_bl - {31'd0, (cur_bl != '0)};

        if (accept && !q_wr.push) begin
            case (cur_phase)
                enbid_pkg::PH_HEADER: begin
                    bytes_left_next = bl_dec;
                    hdr_val = 32'(s_data.data_byte) << {cur_cnt[1:0], 3'b000};
                    hdr_cnt_next = cur_cnt + 4'd1;
                    case (cur_cnt[3:2])
                        2'd0:    name_len_next = cur_name | hdr_val;
                        2'd1:    desc_len_next = cur_desc | hdr_val;
                        default: kind_next     = cur_kind | hdr_val;
                    endcase
                    // Both sizes are complete here; the bound test uses their padded sum.
                    if (cur_cnt == enbid_pkg::HDR_SUM_IDX) begin
                        bound_sum_next = {1'b0, enbid_pkg::pad4(cur_name)}
                                       + {1'b0, enbid_pkg::pad4(cur_desc)};
                    end
                    if (cur_cnt == enbid_pkg::HDR_LAST_IDX) begin
                        if (bound_sum_reg > {2'b00, bl_dec}) begin
                            phase_next = enbid_pkg::PH_DONE;
                            q_wr.push = 1'b1;
                            q_wr.rec.not_found = 1'b1;
                        end else begin
                            match_next = 1'b1;
                            if (cur_name == '0) begin
                                go_desc  = 1'b1;
                                ed_kind  = cur_kind | hdr_val;
                                ed_match = 1'b1;
                            end else begin
                                phase_next = enbid_pkg::PH_NAME;
                                part_left_next = enbid_pkg::pad4(cur_name);
                            end
                        end
                    end
                end
                enbid_pkg::PH_NAME: begin
                    bytes_left_next = bl_dec;
                    // Padded name of size four has at most four bytes left.
                    ed_match = cur_match && (cur_name == enbid_pkg::BUILD_ID_NAME_SIZE)
                             && (s_data.data_byte == enbid_pkg::gnu_tag(
                                    2'(3'd4 - part_left_reg[2:0])));
                    match_next = ed_match;
                    part_left_next = part_left_reg - 33'd1;
                    if (part_left_reg == 33'd1) begin
                        go_desc = 1'b1;
                    end
                end
                enbid_pkg::PH_DESC: begin
                    bytes_left_next = bl_dec;
                    part_left_next = part_left_reg - 33'd1;
                    if (part_left_reg == 33'd1) begin
                        go_end = 1'b1;
                    end
                end
                enbid_pkg::PH_EMIT: begin
                    bytes_left_next = bl_dec;
                    part_left_next = part_left_reg - 33'd1;
                    q_wr.push = 1'b1;
                    q_wr.rec.data = s_data.data_byte;
                    q_wr.rec.last = (part_left_reg == 33'd1);
                    q_wr.rec.id_length = cur_desc;
                    if (part_left_reg == 33'd1) begin
                        phase_next = enbid_pkg::PH_DONE;
                    end
                end
                default: begin
                end
            endcase
        end

        // Entry into the descriptor: build-id, skip, or empty descriptor.
        if (go_desc) begin
            if (ed_kind == enbid_pkg::BUILD_ID_TYPE
                    && cur_name == enbid_pkg::BUILD_ID_NAME_SIZE
                    && cur_desc != '0 && ed_match) begin
                phase_next = enbid_pkg::PH_EMIT;
                part_left_next = {1'b0, cur_desc};
            end else if (cur_desc == '0) begin
                go_end = 1'b1;
            end else begin
                phase_next = enbid_pkg::PH_DESC;
                part_left_next = enbid_pkg::pad4(cur_desc);
            end
        end

        // End of a note: another header must fit in what remains.
        if (go_end) begin
            if (bl_dec < 32'(enbid_pkg::HEADER_BYTES)) begin
                phase_next = enbid_pkg::PH_DONE;
                q_wr.push = 1'b1;
                q_wr.rec.not_found = 1'b1;
            end else begin
                phase_next    = enbid_pkg::PH_HEADER;
                hdr_cnt_next  = '0;
                name_len_next = '0;
                desc_len_next = '0;
                kind_next     = '0;
                match_next    = 1'b0;
            end
        end
    end

    // Parser state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= enbid_pkg::PH_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
        bytes_left_reg <= bytes_left_next;
        hdr_cnt_reg    <= hdr_cnt_next;
        part_left_reg  <= part_left_next;
        name_len_reg   <= name_len_next;
        desc_len_reg   <= desc_len_next;
        kind_reg       <= kind_next;
        match_reg      <= match_next;
        bound_sum_reg  <= bound_sum_next;
    end

endmodule

`default_nettype wire

### design/enbid_queue.sv
// Short record queue between the parser and the emitter of the build-id scanner.
// Register-based circular buffer with a fill count. Depends on enbid_pkg.
`default_nettype none

module enbid_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire enbid_pkg::q_in_t   q_wr,
    input  wire logic               pop,
    output enbid_pkg::q_out_t       q_rd
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    enbid_pkg::rec_t   mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_pop;

    assign do_pop = pop && (count_reg != '0);

    // Head record and fill status.
    assign q_rd.valid = (count_reg != '0);
    assign q_rd.full  = (count_reg == CNT_W'(DEPTH));
    assign q_rd.rec   = mem_reg[rd_ptr_reg];

    // Pointer and count updates with wrap at the depth.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (q_wr.push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(q_wr.push) - CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Record storage.
    always_ff @(posedge aclk) begin
        if (q_wr.push) begin
            mem_reg[wr_ptr_reg] <= q_wr.rec;
        end
    end

endmodule

`default_nettype wire

### design/enbid_back.sv
// Back part of the build-id scanner: turns queued records into result items.
// A build-id byte gives two hex characters; a not-found record gives one item.
// Depends on enbid_pkg.
`default_nettype none

module enbid_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire enbid_pkg::q_out_t q_rd,
    output logic                   pop,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output enbid_pkg::out_t        m_data
);

    logic half_reg, half_next;
    logic take;

    assign m_valid = q_rd.valid;
    assign take    = m_valid && m_ready;
    assign pop     = take && (q_rd.rec.not_found || half_reg);

    // Result item built from the head record.
    always_comb begin
        m_data = '0;
        if (q_rd.rec.not_found) begin
            m_data.status  = 1'b1;
            m_data.is_last = 1'b1;
        end else if (!half_reg) begin
            m_data.hex_char = enbid_pkg::hex_digit(q_rd.rec.data[7:4]);
        end else begin
            m_data.hex_char  = enbid_pkg::hex_digit(q_rd.rec.data[3:0]);
            m_data.is_last   = q_rd.rec.last;
            m_data.id_length = q_rd.rec.last ? q_rd.rec.id_length : '0;
        end
    end

    // Nibble select toggles on each hex character taken.
    always_comb begin
        half_next = half_reg;
        if (take && !q_rd.rec.not_found) begin
            half_next = !half_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_reg <= 1'b0;
        end else begin
            half_reg <= half_next;
        end
    end

endmodule

`default_nettype wire

### design/elf_note_build_id_scanner.sv
// ELF note build-id scanner, top level: parser, record queue and hex emitter.
// Result items come from the registered record queue, behind any records still held in it.
// Throughput: one byte per cycle while the queue has room and headers, names and
// skipped notes are parsed; a build-id byte yields two items on one result port, so
// once the queue (QUEUE_DEPTH records) is full, bytes go as fast as items are taken.
// Reset: synchronous, active low; parser goes idle and the queue is emptied.
`default_nettype none

module elf_note_build_id_scanner #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire enbid_pkg::in_t  s_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output enbid_pkg::out_t      m_data
);

    enbid_pkg::q_in_t  q_wr;
    enbid_pkg::q_out_t q_rd;
    logic              pop;

    enbid_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_rd    (q_rd),
        .q_wr    (q_wr)
    );

    enbid_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_wr    (q_wr),
        .pop     (pop),
        .q_rd    (q_rd)
    );

    enbid_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_rd    (q_rd),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // The parser never writes a record into a full queue.
    assert property (@(posedge aclk) disable iff (!aresetn) q_wr.push |-> !q_rd.full)
        else $error("record pushed into a full queue");

    // A not-found item is always the last item and carries no character or length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status) |->
            (m_data.is_last && m_data.hex_char == 8'h00 && m_data.id_length == '0))
        else $error("malformed not-found item");

    // Only the final hex character carries the build-id length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.is_last) |-> (m_data.id_length == '0))
        else $error("length on a non-final item");

    // Nothing is offered on the result side right after reset.
    assert property (@(posedge aclk) disable iff (!aresetn) $past(!aresetn) |-> !m_valid)
        else $error("result offered right after reset");

endmodule

`default_nettype wire
